// ----- hw/rtl/ppp_pkg.sv -----
// ----------------------------------------------------------------------------
// ppp_pkg
// Shared constants for the perspective point projector: register indexes,
// request modes, the reset viewport and the fixed widths of the arithmetic.
// ----------------------------------------------------------------------------
package ppp_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int CLIP_BITS     = 48;
	localparam int SCR_BITS      = 16;
	localparam int CFG_BITS      = 14;
	localparam int CFG_IDX_BITS  = 4;
	localparam int COEF_BITS     = 32;

	localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 4'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 4'd1;

	localparam logic MODE_LOAD    = 1'b0;
	localparam logic MODE_PROJECT = 1'b1;

	localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 14'd1280;
	localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 14'd720;

endpackage

// ----- hw/rtl/perspective_point_projector.sv -----
// ----------------------------------------------------------------------------
// perspective_point_projector
// Projects points through a loaded 4x4 matrix and maps them to the viewport.
//
//   channel  direction  handshake             payload
//   in       to block   in_valid / in_stall   mode, coef_index, coef_value,
//                                             pos_x, pos_y, pos_z
//   out      from block out_valid / out_stall visible, screen_x, screen_y
//   cfg      to block   cfg_we                cfg_index, cfg_data
//
// One request is taken per clock unless a stall freezes the pipeline.
// A projection passes one input stage, products, row sums, screen offsets,
// the half-size multiply, the divider set-up and sixteen restoring divide
// steps, then the output register. Loads write the matrix when taken and
// give no result. Reset clears the matrix, restores the default viewport and
// empties the pipeline. A stall on a held result freezes every stage at once.
// ----------------------------------------------------------------------------
module perspective_point_projector
	import ppp_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    mode,
	input  logic [3:0]              coef_index,
	input  logic signed [31:0]      coef_value,
	input  logic signed [31:0]      pos_x,
	input  logic signed [31:0]      pos_y,
	input  logic signed [31:0]      pos_z,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    visible,
	output logic signed [15:0]      screen_x,
	output logic signed [15:0]      screen_y,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data
);

	localparam int  QW    = SCR_BITS;
	localparam int  PW    = 2 * COEF_BITS;
	localparam int  SW    = CLIP_BITS + 2;
	localparam int  NW    = 64;
	localparam logic signed [CLIP_BITS-1:0] W_MIN =
		CLIP_BITS'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic signed [CLIP_BITS-1:0] CLIP_HI = {1'b0, {(CLIP_BITS-1){1'b1}}};
	localparam logic signed [CLIP_BITS-1:0] CLIP_LO = {1'b1, {(CLIP_BITS-1){1'b0}}};

	logic adv;
	logic accept;

	logic [CFG_BITS-1:0] width_q, height_q;
	logic signed [COEF_BITS-1:0] mat_q [16];

	// Stage 1: point.
	logic v_s1;
	logic signed [31:0] x_s1, y_s1, z_s1;
	// Stage 2: floored products, index = row*3 + axis.
	logic v_s2;
	logic signed [PW-1:0] prod_s2 [9];
	logic signed [COEF_BITS-1:0] tr_s2 [3];
	// Stage 3: clip components.
	logic v_s3;
	logic signed [CLIP_BITS-1:0] cx_s3, cy_s3, w_s3;
	// Stage 4: screen offsets.
	logic v_s4, vis_s4;
	logic signed [SW-1:0] sx_s4, sy_s4;
	logic signed [CLIP_BITS-1:0] w_s4;
	// Stage 5: scaled numerators.
	logic v_s5, vis_s5;
	logic signed [NW-1:0] nx_s5, ny_s5;
	logic [NW-1:0] w_s5;

	// Divider stages 0..QW.
	logic            dv_s   [QW+1];
	logic            dvis_s [QW+1];
	logic [NW-1:0]   dw_s   [QW+1];
	logic [NW-1:0]   rx_s   [QW+1];
	logic [NW-1:0]   ry_s   [QW+1];
	logic [QW-1:0]   qx_s   [QW+1];
	logic [QW-1:0]   qy_s   [QW+1];
	logic            negx_s [QW+1];
	logic            negy_s [QW+1];
	logic            ovx_s  [QW+1];
	logic            ovy_s  [QW+1];

	logic [NW-1:0] rx_nxt [QW];
	logic [NW-1:0] ry_nxt [QW];
	logic [QW-1:0] qx_nxt [QW];
	logic [QW-1:0] qy_nxt [QW];

	logic signed [CLIP_BITS-1:0] row_sat [3];
	logic [NW-1:0] ax_c, ay_c, wlim_c;
	logic signed [QW-1:0] fx_c, fy_c;

	logic vis_q;
	logic signed [QW-1:0] sx_q, sy_q;
	logic ov_q;

	assign adv      = !ov_q || !out_stall;
	assign in_stall = !adv;
	assign accept   = in_valid && adv;

	// Configuration and matrix store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			for (int i = 0; i < 16; i++) mat_q[i] <= '0;
		end else begin
			if (cfg_we && cfg_index == REG_SCREEN_WIDTH) width_q <= cfg_data;
			if (cfg_we && cfg_index == REG_SCREEN_HEIGHT) height_q <= cfg_data;
			if (accept && mode == MODE_LOAD) mat_q[coef_index] <= coef_value;
		end
	end

	// Row sums of the floored products and the translation, saturated.
	always_comb begin
		logic signed [PW+1:0] acc;
		for (int r = 0; r < 3; r++) begin
			acc = (PW+2)'(prod_s2[r*3]) + (PW+2)'(prod_s2[r*3+1]) +
				(PW+2)'(prod_s2[r*3+2]) + (PW+2)'(tr_s2[r]);
			if (acc > (PW+2)'(CLIP_HI)) row_sat[r] = CLIP_HI;
			else if (acc < (PW+2)'(CLIP_LO)) row_sat[r] = CLIP_LO;
			else row_sat[r] = acc[CLIP_BITS-1:0];
		end
	end

	// Divider set-up: magnitudes and the quotient overflow check.
	always_comb begin
		ax_c   = nx_s5[NW-1] ? NW'(-nx_s5) : NW'(nx_s5);
		ay_c   = ny_s5[NW-1] ? NW'(-ny_s5) : NW'(ny_s5);
		wlim_c = w_s5 << QW;
	end

	// One restoring step per divider stage, most significant bit first.
	always_comb begin
		logic [NW-1:0] trial;
		for (int k = 0; k < QW; k++) begin
			trial     = dw_s[k] << (QW - 1 - k);
			rx_nxt[k] = rx_s[k];
			ry_nxt[k] = ry_s[k];
			qx_nxt[k] = qx_s[k];
			qy_nxt[k] = qy_s[k];
			if (rx_s[k] >= trial) begin
				rx_nxt[k] = rx_s[k] - trial;
				qx_nxt[k][QW-1-k] = 1'b1;
			end
			if (ry_s[k] >= trial) begin
				ry_nxt[k] = ry_s[k] - trial;
				qy_nxt[k][QW-1-k] = 1'b1;
			end
		end
	end

	// Sign and 16-bit saturation of the truncated quotients.
	always_comb begin
		logic [QW:0] ux, uy;
		ux = {1'b0, qx_s[QW]};
		uy = {1'b0, qy_s[QW]};
		if (negx_s[QW]) begin
			if (ovx_s[QW] || ux > (QW+1)'(1 << (QW-1))) fx_c = {1'b1, {(QW-1){1'b0}}};
			else fx_c = QW'(-ux);
		end else begin
			if (ovx_s[QW] || ux > (QW+1)'((1 << (QW-1)) - 1)) fx_c = {1'b0, {(QW-1){1'b1}}};
			else fx_c = QW'(ux);
		end
		if (negy_s[QW]) begin
			if (ovy_s[QW] || uy > (QW+1)'(1 << (QW-1))) fy_c = {1'b1, {(QW-1){1'b0}}};
			else fy_c = QW'(-uy);
		end else begin
			if (ovy_s[QW] || uy > (QW+1)'((1 << (QW-1)) - 1)) fy_c = {1'b0, {(QW-1){1'b1}}};
			else fy_c = QW'(uy);
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int k = 0; k <= QW; k++) dv_s[k] <= 1'b0;
			ov_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid && mode == MODE_PROJECT;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			dv_s[0] <= v_s5;
			for (int k = 0; k < QW; k++) dv_s[k+1] <= dv_s[k];
			ov_q <= dv_s[QW];
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= pos_x;
			y_s1 <= pos_y;
			z_s1 <= pos_z;

			for (int r = 0; r < 3; r++) begin
				// Rows 0, 1 and 3 of the matrix give cx, cy and w.
				prod_s2[r*3]   <= (PW'(x_s1) * PW'(mat_q[(r == 2) ? 3 : r])) >>> FRAC_BITS;
				prod_s2[r*3+1] <= (PW'(y_s1) * PW'(mat_q[((r == 2) ? 3 : r) + 4])) >>> FRAC_BITS;
				prod_s2[r*3+2] <= (PW'(z_s1) * PW'(mat_q[((r == 2) ? 3 : r) + 8])) >>> FRAC_BITS;
				tr_s2[r]       <= mat_q[((r == 2) ? 3 : r) + 12];
			end

			cx_s3 <= row_sat[0];
			cy_s3 <= row_sat[1];
			w_s3  <= row_sat[2];

			vis_s4 <= w_s3 >= W_MIN;
			sx_s4  <= SW'(cx_s3) + SW'(w_s3);
			sy_s4  <= SW'(w_s3) - SW'(cy_s3);
			w_s4   <= w_s3;

			vis_s5 <= vis_s4;
			nx_s5  <= NW'($signed({1'b0, width_q[CFG_BITS-1:1]})) * NW'(sx_s4);
			ny_s5  <= NW'($signed({1'b0, height_q[CFG_BITS-1:1]})) * NW'(sy_s4);
			w_s5   <= NW'(w_s4);

			dvis_s[0] <= vis_s5;
			dw_s[0]   <= w_s5;
			rx_s[0]   <= ax_c;
			ry_s[0]   <= ay_c;
			qx_s[0]   <= '0;
			qy_s[0]   <= '0;
			negx_s[0] <= nx_s5[NW-1];
			negy_s[0] <= ny_s5[NW-1];
			ovx_s[0]  <= ax_c >= wlim_c;
			ovy_s[0]  <= ay_c >= wlim_c;
			for (int k = 0; k < QW; k++) begin
				dvis_s[k+1] <= dvis_s[k];
				dw_s[k+1]   <= dw_s[k];
				rx_s[k+1]   <= rx_nxt[k];
				ry_s[k+1]   <= ry_nxt[k];
				qx_s[k+1]   <= qx_nxt[k];
				qy_s[k+1]   <= qy_nxt[k];
				negx_s[k+1] <= negx_s[k];
				negy_s[k+1] <= negy_s[k];
				ovx_s[k+1]  <= ovx_s[k];
				ovy_s[k+1]  <= ovy_s[k];
			end

			vis_q <= dvis_s[QW];
			sx_q  <= dvis_s[QW] ? fx_c : '0;
			sy_q  <= dvis_s[QW] ? fy_c : '0;
		end
	end

	assign out_valid = ov_q;
	assign visible   = vis_q;
	assign screen_x  = sx_q;
	assign screen_y  = sy_q;

	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !visible |-> screen_x == '0 && screen_y == '0)
		else $error("hidden point with nonzero screen position");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && mode == MODE_LOAD |=> !v_s1)
		else $error("matrix load entered the pipeline");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		dv_s[QW] && dvis_s[QW] && !ovx_s[QW] |-> rx_s[QW] < dw_s[QW])
		else $error("divider remainder not below divisor");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(dv_s[0]) && $stable(v_s5))
		else $error("pipeline moved during stall");

endmodule
